/* rtl/core/lfopn_pkg.sv */
package lfopn_pkg;

  // datapath widths (fixed by the Q formats of the fields)
  localparam int STEP_W   = 4;
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 23;
  localparam int CFG_IX_W = 3;
  localparam int MIX_W    = 16;
  localparam int WQ_W     = 26;   // white noise in Q.25
  localparam int SUM_W    = 28;   // wave sum and wave average
  localparam int PINK_W   = 35;   // pole sum and pink noise
  localparam int POLE_W   = 32;
  localparam int OPA_W    = 35;
  localparam int OPB_W    = 26;
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int ACC_W    = PROD_W + 1;

  localparam logic [MIX_W-1:0] MIX_ONE = 16'd32768;

  localparam logic signed [SUM_W-1:0] ONE24   = 28'sd16777216;
  localparam logic signed [SUM_W-1:0] THREE24 = 28'sd50331648;

  // filter and scaling coefficients, signed Q2.24; K_THIRD is 1/3 in Q.18
  localparam logic signed [OPB_W-1:0] K_A0    = 26'sd16737790;
  localparam logic signed [OPB_W-1:0] K_A1    = 26'sd16156459;
  localparam logic signed [OPB_W-1:0] K_A2    = 26'sd9563013;
  localparam logic signed [OPB_W-1:0] K_B0    = 26'sd1661716;
  localparam logic signed [OPB_W-1:0] K_B1    = 26'sd4974720;
  localparam logic signed [OPB_W-1:0] K_B2    = 26'sd17661229;
  localparam logic signed [OPB_W-1:0] K_WHITE = 26'sd3100430;
  localparam logic signed [OPB_W-1:0] K_PINK  = 26'sd3690988;
  localparam logic signed [OPB_W-1:0] K_THIRD = 26'sd87381;

  localparam logic signed [ACC_W-1:0]  ACC_HALF24  = 62'sd8388608;
  localparam logic signed [ACC_W-1:0]  ACC_HALF22  = 62'sd2097152;
  localparam logic signed [PROD_W-1:0] PROD_HALF24 = 61'sd8388608;
  localparam logic signed [PROD_W-1:0] PROD_HALF18 = 61'sd131072;

  localparam logic signed [ACC_W-1:0] POLE_MAX = 62'sd2147483647;
  localparam logic signed [ACC_W-1:0] POLE_MIN = -62'sd2147483648;
  localparam logic signed [ACC_W-1:0] OUT_MAX  = 62'sd8388607;
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -62'sd8388608;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_PHASE_STEP = 3'd0,
    REG_SAW_EN     = 3'd1,
    REG_TRI_EN     = 3'd2,
    REG_SQ_EN      = 3'd3,
    REG_NOISE_MIX  = 3'd4
  } reg_ix_t;

  typedef enum logic [2:0] {
    OPA_POLE0, OPA_POLE1, OPA_POLE2, OPA_WN,
    OPA_SUM, OPA_WAVE, OPA_PINKSUM, OPA_PINK
  } opa_t;

  typedef enum logic [3:0] {
    CF_A0, CF_A1, CF_A2, CF_B0, CF_B1, CF_B2,
    CF_WHITE, CF_PINK, CF_THIRD, CF_MIXW, CF_MIXN
  } coef_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_WAVE3, WB_POLE0, WB_POLE1, WB_POLE2, WB_PINKSUM, WB_PINK, WB_OUT
  } wb_t;

  typedef enum logic {
    JMP_NONE, JMP_NOT3
  } jmp_t;

  typedef struct packed {
    opa_t              opa;
    coef_t             coef;
    acc_op_t           acc;
    wb_t               wb;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic  busy;
    logic  fire;
    ctrl_t ctrl;
  } seq_out_t;

  function automatic ctrl_t mk(input opa_t opa, input coef_t coef, input acc_op_t acc,
                               input wb_t wb, input jmp_t jmp,
                               input logic [STEP_W-1:0] target, input logic last);
    ctrl_t c;
    c.opa    = opa;
    c.coef   = coef;
    c.acc    = acc;
    c.wb     = wb;
    c.jmp    = jmp;
    c.target = target;
    c.last   = last;
    return c;
  endfunction

  // product issued in a step lands in the product register at its end,
  // so accumulate and write-back fields act one step behind the multiply
  function automatic ctrl_t lfopn_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    unique case (step)
      4'd0:  c = mk(OPA_SUM,     CF_THIRD, ACC_HOLD, WB_NONE,    JMP_NOT3, 4'd2, 1'b0);
      4'd1:  c = mk(OPA_SUM,     CF_THIRD, ACC_HOLD, WB_WAVE3,   JMP_NONE, 4'd0, 1'b0);
      4'd2:  c = mk(OPA_POLE0,   CF_A0,    ACC_HOLD, WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd3:  c = mk(OPA_WN,      CF_B0,    ACC_LOAD, WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd4:  c = mk(OPA_POLE1,   CF_A1,    ACC_ADD,  WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd5:  c = mk(OPA_WN,      CF_B1,    ACC_LOAD, WB_POLE0,   JMP_NONE, 4'd0, 1'b0);
      4'd6:  c = mk(OPA_POLE2,   CF_A2,    ACC_ADD,  WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd7:  c = mk(OPA_WN,      CF_B2,    ACC_LOAD, WB_POLE1,   JMP_NONE, 4'd0, 1'b0);
      4'd8:  c = mk(OPA_WN,      CF_WHITE, ACC_ADD,  WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd9:  c = mk(OPA_WAVE,    CF_MIXW,  ACC_LOAD, WB_POLE2,   JMP_NONE, 4'd0, 1'b0);
      4'd10: c = mk(OPA_SUM,     CF_THIRD, ACC_LOAD, WB_PINKSUM, JMP_NONE, 4'd0, 1'b0);
      4'd11: c = mk(OPA_PINKSUM, CF_PINK,  ACC_HOLD, WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd12: c = mk(OPA_PINKSUM, CF_PINK,  ACC_HOLD, WB_PINK,    JMP_NONE, 4'd0, 1'b0);
      4'd13: c = mk(OPA_PINK,    CF_MIXN,  ACC_HOLD, WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd14: c = mk(OPA_PINK,    CF_MIXN,  ACC_ADD,  WB_NONE,    JMP_NONE, 4'd0, 1'b0);
      4'd15: c = mk(OPA_PINK,    CF_MIXN,  ACC_HOLD, WB_OUT,     JMP_NONE, 4'd0, 1'b1);
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/lfopn_if.sv */
interface lfopn_in_if #(parameter int NOISE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [NOISE_BITS-1:0] white_noise;

  modport source (output valid, output white_noise, input ready);
  modport sink (input valid, input white_noise, output ready);
endinterface

interface lfopn_out_if;
  import lfopn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] mod_value;

  modport source (output valid, output mod_value, input ready);
  modport sink (input valid, input mod_value, output ready);
endinterface

/* rtl/core/lfo_with_pink_noise_mix.sv */
// channel   dir  handshake          payload
// in_ch     in   valid / ready      white_noise  (NOISE_BITS, signed Q1.15)
// out_ch    out  valid / ready      mod_value    (24, signed Q6.18)
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_wdata
//
// a request is taken when the sequencer is idle and runs 16 steps (15 when fewer
// than three waves are on); the next request is taken only once the sequencer is
// idle again; all steps share the one 35x26 multiplier, used for ten or eleven
// products per item
// sync reset clears configuration, phase, filter poles and the output valid
// the final step holds while a finished result waits on out_ch, so the next
// request can be taken and worked on behind an unclaimed result
module lfo_with_pink_noise_mix #(
  parameter int PHASE_BITS = 24,
  parameter int NOISE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lfopn_in_if.sink                         in_ch,
  lfopn_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [lfopn_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [lfopn_pkg::CFG_W-1:0]      cfg_wdata
);
  import lfopn_pkg::*;

  localparam int WQ_SH = WQ_W - NOISE_BITS;

  // configuration
  logic [CFG_W-1:0] phase_step_r;
  logic             saw_en_r, tri_en_r, sq_en_r;
  logic [MIX_W-1:0] noise_mix_r;

  // state and datapath
  logic [PHASE_BITS-1:0]    wave_phase_r;
  logic signed [POLE_W-1:0] pole_r [3];
  logic signed [WQ_W-1:0]   w_r;
  logic signed [SUM_W-1:0]  sum_r, wave_r;
  logic signed [PINK_W-1:0] pinksum_r, pink_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  mod_value_r;

  seq_out_t seq;
  logic     in_acc;
  logic     three_wave;
  logic     hold;

  // wave generation at accept
  logic [PHASE_BITS+23:0]       ph_ext;
  logic [23:0]                  p_q24;
  logic                         first_half;
  logic signed [SUM_W-1:0]      p4, saw_term, tri_term, sq_term, sum_nxt, wave_init;
  logic [1:0]                   n_en;
  logic signed [NOISE_BITS-1:0] wn;
  logic signed [WQ_W-1:0]       w_nxt;

  logic [MIX_W-1:0]         m_clamp, m_wave;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [ACC_W-1:0]  acc_sh24, acc_sh22;
  logic signed [PROD_W-1:0] prod_sh24, prod_sh18;
  logic signed [POLE_W-1:0] pole_sat;
  logic signed [OUT_W-1:0]  out_sat;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !seq.busy;
  assign hold       = out_valid_r && !out_ch.ready;
  assign n_en       = {1'b0, saw_en_r} + {1'b0, tri_en_r} + {1'b0, sq_en_r};
  assign three_wave = (n_en == 2'd3);

  lfopn_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .hold       (hold),
    .three_wave (three_wave),
    .seq        (seq)
  );

  // phase as Q0.24, whatever the accumulator width
  assign ph_ext     = {wave_phase_r, 24'b0};
  assign p_q24      = ph_ext[PHASE_BITS+23 -: 24];
  assign first_half = ~p_q24[23];
  assign p4         = signed'({2'b00, p_q24, 2'b00});

  always_comb begin
    saw_term = saw_en_r ? signed'({4'b0000, p_q24}) : '0;
    tri_term = '0;
    if (tri_en_r) begin
      tri_term = first_half ? (p4 - ONE24) : (THREE24 - p4);
    end
    sq_term   = (sq_en_r && first_half) ? ONE24 : '0;
    sum_nxt   = saw_term + tri_term + sq_term;
    // two waves: the Q.24 sum is already the Q.25 average
    wave_init = (n_en == 2'd2) ? sum_nxt : (sum_nxt <<< 1);
  end

  assign wn    = in_ch.white_noise;
  assign w_nxt = WQ_W'(wn) <<< WQ_SH;

  assign m_clamp = (noise_mix_r > MIX_ONE) ? MIX_ONE : noise_mix_r;
  assign m_wave  = MIX_ONE - m_clamp;

  // shared multiplier operands
  always_comb begin
    unique case (seq.ctrl.opa)
      OPA_POLE0:   op_a = OPA_W'(pole_r[0]);
      OPA_POLE1:   op_a = OPA_W'(pole_r[1]);
      OPA_POLE2:   op_a = OPA_W'(pole_r[2]);
      OPA_WN:      op_a = OPA_W'(w_r);
      OPA_SUM:     op_a = OPA_W'(sum_r);
      OPA_WAVE:    op_a = OPA_W'(wave_r);
      OPA_PINKSUM: op_a = OPA_W'(pinksum_r);
      OPA_PINK:    op_a = OPA_W'(pink_r);
    endcase
  end

  always_comb begin
    unique case (seq.ctrl.coef)
      CF_A0:    op_b = K_A0;
      CF_A1:    op_b = K_A1;
      CF_A2:    op_b = K_A2;
      CF_B0:    op_b = K_B0;
      CF_B1:    op_b = K_B1;
      CF_B2:    op_b = K_B2;
      CF_WHITE: op_b = K_WHITE;
      CF_PINK:  op_b = K_PINK;
      CF_THIRD: op_b = K_THIRD;
      CF_MIXW:  op_b = signed'({{(OPB_W-MIX_W){1'b0}}, m_wave});
      CF_MIXN:  op_b = signed'({{(OPB_W-MIX_W){1'b0}}, m_clamp});
      default:  op_b = '0;
    endcase
  end

  assign prod_nxt = op_a * op_b;

  always_comb begin
    unique case (seq.ctrl.acc)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // round half up, then saturate the accumulator results
  assign acc_sh24  = (acc_r + ACC_HALF24) >>> 24;
  assign acc_sh22  = (acc_r + ACC_HALF22) >>> 22;
  assign prod_sh24 = (prod_r + PROD_HALF24) >>> 24;
  assign prod_sh18 = (prod_r + PROD_HALF18) >>> 18;

  always_comb begin
    priority if (acc_sh24 > POLE_MAX) begin
      pole_sat = POLE_W'(POLE_MAX);
    end else if (acc_sh24 < POLE_MIN) begin
      pole_sat = POLE_W'(POLE_MIN);
    end else begin
      pole_sat = POLE_W'(acc_sh24);
    end
  end

  always_comb begin
    priority if (acc_sh22 > OUT_MAX) begin
      out_sat = OUT_W'(OUT_MAX);
    end else if (acc_sh22 < OUT_MIN) begin
      out_sat = OUT_W'(OUT_MIN);
    end else begin
      out_sat = OUT_W'(acc_sh22);
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      saw_en_r     <= 1'b0;
      tri_en_r     <= 1'b0;
      sq_en_r      <= 1'b0;
      noise_mix_r  <= '0;
      wave_phase_r <= '0;
      pole_r[0]    <= '0;
      pole_r[1]    <= '0;
      pole_r[2]    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_STEP: phase_step_r <= cfg_wdata;
          REG_SAW_EN:     saw_en_r     <= cfg_wdata[0];
          REG_TRI_EN:     tri_en_r     <= cfg_wdata[0];
          REG_SQ_EN:      sq_en_r      <= cfg_wdata[0];
          REG_NOISE_MIX:  noise_mix_r  <= cfg_wdata[MIX_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        wave_phase_r <= wave_phase_r + PHASE_BITS'(phase_step_r);
      end
      if (seq.fire) begin
        unique case (seq.ctrl.wb)
          WB_POLE0: pole_r[0] <= pole_sat;
          WB_POLE1: pole_r[1] <= pole_sat;
          WB_POLE2: pole_r[2] <= pole_sat;
          default: ;
        endcase
      end
      if (seq.fire && seq.ctrl.wb == WB_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r    <= w_nxt;
      sum_r  <= sum_nxt;
      wave_r <= wave_init;
    end
    if (seq.busy) begin
      prod_r <= prod_nxt;
    end
    if (seq.fire) begin
      acc_r <= acc_nxt;
      unique case (seq.ctrl.wb)
        WB_WAVE3:   wave_r      <= SUM_W'(prod_sh18) <<< 1;
        WB_PINKSUM: pinksum_r   <= PINK_W'(pole_r[0]) + PINK_W'(pole_r[1])
                                   + PINK_W'(pole_r[2]) + PINK_W'(acc_sh24);
        WB_PINK:    pink_r      <= PINK_W'(prod_sh24);
        WB_OUT:     mod_value_r <= out_sat;
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.mod_value = mod_value_r;

endmodule

/* rtl/core/lfopn_seq.sv */
module lfopn_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               hold,
  input  logic               three_wave,
  output lfopn_pkg::seq_out_t seq
);
  import lfopn_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_t             ctrl;
  logic              fire;

  assign ctrl = lfopn_ucode(step_r);
  // the last step waits while the previous result is still unclaimed
  assign fire = busy_r && !(ctrl.last && hold);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (fire) begin
      if (ctrl.last) begin
        busy_nxt = 1'b0;
      end else begin
        unique case (ctrl.jmp)
          JMP_NOT3: step_nxt = three_wave ? step_r + 4'd1 : ctrl.target;
          JMP_NONE: step_nxt = step_r + 4'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign seq.busy = busy_r;
  assign seq.fire = fire;
  assign seq.ctrl = ctrl;

endmodule

/* rtl/core/lfopn_chk.sv */
module lfopn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] mod_value
);

  // reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("output valid or input closed after reset");

  // a taken request closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a request was taken");

  // a new result only comes out of a running sequence
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mod_value))
    else $error("stalled result changed");

endmodule

bind lfo_with_pink_noise_mix lfopn_chk u_lfopn_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mod_value (out_ch.mod_value)
);
